// ===== design/cfb_pkg.sv =====
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared constants and types for the command frame builder: marker bytes,
// positions of each byte within one run and the run descriptor.
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam int unsigned StartLen = 12;
  localparam int unsigned EndLen   = 8;

  localparam logic [7:0] START_MARK [StartLen] = '{
    8'd66, 8'd0, 8'd89, 8'd0, 8'd72, 8'd0, 8'd88, 8'd0, 8'd48, 8'd0, 8'd49, 8'd0
  };
  localparam logic [7:0] END_MARK [EndLen] = '{
    8'd66, 8'd0, 8'd89, 8'd0, 8'd72, 8'd0, 8'd88, 8'd0
  };

  // length byte is parameter count plus the length and both command bytes
  localparam logic [7:0] LEN_OFFSET = 8'd3;

  typedef logic [4:0] pos_t;

  // byte positions of a full run: start marker, header, payload, sum, end marker
  localparam pos_t POS_START = 5'd0;
  localparam pos_t POS_LEN   = 5'd12;
  localparam pos_t POS_PRI   = 5'd13;
  localparam pos_t POS_SEC   = 5'd14;
  localparam pos_t POS_PARAM = 5'd15;
  localparam pos_t POS_SUM   = 5'd16;
  localparam pos_t POS_END0  = 5'd17;
  localparam pos_t POS_LAST  = 5'd24;

  typedef struct packed {
    logic       drop;     // word without an open frame, gives a single zero byte
    logic       err;
    logic [7:0] len_byte;
    logic [7:0] pri;
    logic [7:0] sec;
    logic [7:0] param;
    logic [7:0] sum;
    pos_t       end_pos;
  } run_t;

endpackage

// ===== design/command_frame_builder_top.sv =====
// ----------------------------------------------------------------------------
// command_frame_builder_top
// Frames a stream of parameter bytes as a command packet.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one parameter byte per word. A word
// with first_of_frame set also carries both command bytes and the parameter
// length, and produces the 12-byte start marker, length, commands and its
// parameter byte. A last_of_frame word in an open frame adds the modular sum
// and 8-byte end marker. Other framed words give their parameter byte alone.
// Output channel (out_valid / out_stall): one frame byte per word, with
// last_of_run on the final byte caused by an input word and frame_done on the
// last end-marker byte.
// A word with no open frame gives a single zero byte. An accepted word is held
// in the run register before its bytes move to the output register.
// Throughput while out_stall is low: one output byte per cycle; an input word
// that makes n bytes holds the input while they go out, so plain payload words
// flow one per cycle. The run sequencer takes the next word in the cycle its
// last byte moves to the output register.
// Reset clears the open frame, the counters and both valid flags.
// While out_stall is high on a valid output word, that word holds and the input
// stalls as long as a run is pending.
// ----------------------------------------------------------------------------
module command_frame_builder_top
  import cfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       first_of_frame,
  input  logic [7:0] cmd_primary,
  input  logic [7:0] cmd_secondary,
  input  logic [7:0] param_len,
  input  logic [7:0] param_byte,
  input  logic       last_of_frame,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] frame_byte,
  output logic       last_of_run,
  output logic       frame_done,
  output logic       length_error
);

  // frame state
  logic       in_frame, in_frame_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic [7:0] declared_len, declared_len_next;
  logic [7:0] running_sum, running_sum_next;

  // run sequencer
  logic run_valid;
  run_t run, run_next;
  pos_t pos;
  pos_t start_pos;

  logic       out_load, at_end, run_adv, in_acc;
  logic [7:0] byte_sel;
  logic [7:0] len_byte, seen_inc, sum_new;
  logic       err;
  pos_t       end_off;

  assign out_load = !out_valid || !out_stall;
  assign at_end   = (pos == run.end_pos);
  assign run_adv  = run_valid && out_load;
  assign in_stall = run_valid && !(out_load && at_end);
  assign in_acc   = in_valid && !in_stall;

  // frame bookkeeping for the word at the input
  always_comb begin
    len_byte = param_len + LEN_OFFSET;
    seen_inc = (bytes_seen == 8'hFF) ? bytes_seen : bytes_seen + 8'd1;
    in_frame_next     = in_frame;
    bytes_seen_next   = bytes_seen;
    declared_len_next = declared_len;
    running_sum_next  = running_sum;
    sum_new = running_sum + param_byte;
    err     = 1'b1;
    start_pos = POS_PARAM;
    run_next  = '0;

    if (first_of_frame) begin
      sum_new = len_byte + cmd_primary + cmd_secondary + param_byte;
      err = in_frame || (last_of_frame ? (param_len != 8'd1) : (param_len == 8'd0));
      in_frame_next     = 1'b1;
      bytes_seen_next   = 8'd1;
      declared_len_next = param_len;
      running_sum_next  = sum_new;
      start_pos = POS_START;
    end else if (in_frame) begin
      err = last_of_frame ? (seen_inc != declared_len) : (seen_inc > declared_len);
      bytes_seen_next  = seen_inc;
      running_sum_next = sum_new;
    end

    // closing word empties the frame state
    if ((first_of_frame || in_frame) && last_of_frame) begin
      in_frame_next     = 1'b0;
      bytes_seen_next   = 8'd0;
      declared_len_next = 8'd0;
      running_sum_next  = 8'd0;
    end

    run_next.drop     = !first_of_frame && !in_frame;
    run_next.err      = err;
    run_next.len_byte = len_byte;
    run_next.pri      = cmd_primary;
    run_next.sec      = cmd_secondary;
    run_next.param    = param_byte;
    run_next.sum      = sum_new;
    run_next.end_pos  = (last_of_frame && !run_next.drop) ? POS_LAST : POS_PARAM;
  end

  // byte at the current run position
  always_comb begin
    end_off = pos - POS_END0;
    if (pos < POS_LEN) begin
      byte_sel = START_MARK[pos[3:0]];
    end else begin
      case (pos)
        POS_LEN:   byte_sel = run.len_byte;
        POS_PRI:   byte_sel = run.pri;
        POS_SEC:   byte_sel = run.sec;
        POS_PARAM: byte_sel = run.drop ? 8'd0 : run.param;
        POS_SUM:   byte_sel = run.sum;
        default:   byte_sel = END_MARK[end_off[2:0]];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      bytes_seen   <= 8'd0;
      declared_len <= 8'd0;
      running_sum  <= 8'd0;
      run_valid    <= 1'b0;
      out_valid    <= 1'b0;
      pos          <= POS_START;
    end else begin
      if (in_acc) begin
        in_frame     <= in_frame_next;
        bytes_seen   <= bytes_seen_next;
        declared_len <= declared_len_next;
        running_sum  <= running_sum_next;
        run_valid    <= 1'b1;
        pos          <= start_pos;
      end else if (run_adv) begin
        if (at_end) begin
          run_valid <= 1'b0;
        end
        pos <= pos + 5'd1;
      end
      if (out_load) begin
        out_valid <= run_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      run <= run_next;
    end
    if (run_adv) begin
      frame_byte   <= byte_sel;
      last_of_run  <= at_end;
      frame_done   <= (pos == POS_LAST);
      length_error <= run.err;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for command_frame_builder_top. Parameter bytes are sent
// as frames of random shape: mostly well formed, some with wrong counts,
// dropped first flags, abandoned frames and stray words. A scoreboard keeps
// its own copy of the frame state, predicts every framed byte and compares
// each byte leaving the block against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import cfb_pkg::*;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       first_of_frame;
  logic [7:0] cmd_primary;
  logic [7:0] cmd_secondary;
  logic [7:0] param_len;
  logic [7:0] param_byte;
  logic       last_of_frame;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] frame_byte;
  logic       last_of_run;
  logic       frame_done;
  logic       length_error;

  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
    logic       done;
    logic       err;
  } frame_beat_t;

  class frame_scoreboard;
    frame_beat_t pending_bytes[$];
    logic        in_frame;
    logic [7:0]  bytes_seen;
    logic [7:0]  declared_len;
    logic [7:0]  running_sum;
    int          run_left;
    int          n_words;
    int          n_checked;
    int          n_mismatch;
    int          n_frames;
    int          n_bad_frames;
    int          n_dropped;
    int          n_abandoned;

    function new();
      in_frame     = 1'b0;
      bytes_seen   = '0;
      declared_len = '0;
      running_sum  = '0;
      run_left     = 0;
      n_words      = 0;
      n_checked    = 0;
      n_mismatch   = 0;
      n_frames     = 0;
      n_bad_frames = 0;
      n_dropped    = 0;
      n_abandoned  = 0;
    endfunction

    function void note_mismatch(string msg);
      n_mismatch++;
      if (n_mismatch <= 10) $display("mismatch: %s", msg);
    endfunction

    // run_end goes on the byte that uses up the run
    function void emit(logic [7:0] value, logic done, logic err);
      frame_beat_t beat;
      beat.value   = value;
      beat.run_end = (run_left == 1);
      beat.done    = done;
      beat.err     = err;
      pending_bytes = {pending_bytes, beat};
      run_left--;
    endfunction

    function void note_word(logic first, logic [7:0] pri, logic [7:0] sec,
                            logic [7:0] plen, logic [7:0] pb, logic last);
      logic       err;
      logic       abandoned;
      logic [7:0] len_byte;
      n_words++;
      if (!first && !in_frame) begin
        // no open frame: a single zero byte flagged in error, state untouched
        run_left = 1;
        emit(8'd0, 1'b0, 1'b1);
        n_dropped++;
        return;
      end
      if (first) begin
        run_left     = StartLen + 4 + (last ? EndLen + 1 : 0);
        len_byte     = plen + LEN_OFFSET;
        abandoned    = in_frame;
        in_frame     = 1'b1;
        declared_len = plen;
        bytes_seen   = 8'd1;
        running_sum  = len_byte + pri + sec + pb;
        err = abandoned || (last ? (bytes_seen != declared_len)
                                 : (bytes_seen > declared_len));
        if (abandoned) n_abandoned++;
        for (int i = 0; i < StartLen; i++) emit(START_MARK[4'(i)], 1'b0, err);
        emit(len_byte, 1'b0, err);
        emit(pri, 1'b0, err);
        emit(sec, 1'b0, err);
        emit(pb, 1'b0, err);
      end else begin
        run_left = 1 + (last ? EndLen + 1 : 0);
        if (bytes_seen != 8'hff) bytes_seen++;
        running_sum = running_sum + pb;
        err = last ? (bytes_seen != declared_len) : (bytes_seen > declared_len);
        emit(pb, 1'b0, err);
      end
      if (last) begin
        emit(running_sum, 1'b0, err);
        for (int i = 0; i < EndLen; i++) emit(END_MARK[3'(i)], i == EndLen - 1, err);
        n_frames++;
        if (err) n_bad_frames++;
        in_frame     = 1'b0;
        bytes_seen   = '0;
        declared_len = '0;
        running_sum  = '0;
      end
    endfunction

    function void check_result(logic [7:0] value, logic run_end, logic done,
                               logic err);
      frame_beat_t want;
      if (pending_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %0d last %0b done %0b err %0b",
                                value, run_end, done, err));
        return;
      end
      want = pending_bytes.pop_front();
      n_checked++;
      if (want.value != value || want.run_end != run_end || want.done != done ||
          want.err != err)
        note_mismatch($sformatf(
          "byte %0d: want %0d last %0b done %0b err %0b, got %0d %0b %0b %0b",
          n_checked, want.value, want.run_end, want.done, want.err,
          value, run_end, done, err));
    endfunction

    function void check_drained();
      if (pending_bytes.size() != 0)
        note_mismatch($sformatf("%0d predicted bytes never came out",
                                pending_bytes.size()));
    endfunction
  endclass

  frame_scoreboard sb = new();
  logic quiet_sender = 1'b0;
  logic pressure_done = 1'b0;

  command_frame_builder_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .first_of_frame(first_of_frame),
    .cmd_primary   (cmd_primary),
    .cmd_secondary (cmd_secondary),
    .param_len     (param_len),
    .param_byte    (param_byte),
    .last_of_frame (last_of_frame),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .last_of_run   (last_of_run),
    .frame_done    (frame_done),
    .length_error  (length_error)
  );

  always #2 clk = ~clk;

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(frame_byte, last_of_run, frame_done, length_error);
  end

  // output side: random stall stretches, plus one long hold that backs up the input
  initial begin
    int len;
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressure_done && sb.n_words >= 40) begin
        out_stall = 1'b1;
        hold = 0;
        while (hold < 200) begin
          @(negedge clk);
          hold++;
        end
        out_stall = 1'b0;
        pressure_done = 1'b1;
      end else begin
        len = $urandom_range(0, 99);
        if (len < 30) begin
          out_stall = 1'b0;
          repeat ($urandom_range(10, 60)) @(negedge clk);
        end else if (len < 80) begin
          out_stall = 1'b1;
          repeat ($urandom_range(0, 2)) @(negedge clk);
        end else if (len < 95) begin
          out_stall = 1'b1;
          repeat ($urandom_range(3, 11)) @(negedge clk);
        end else begin
          out_stall = 1'b1;
          repeat ($urandom_range(19, 39)) @(negedge clk);
        end
      end
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_sender || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // entered and left at a falling edge
  task automatic send_word(logic first, logic [7:0] pri, logic [7:0] sec,
                           logic [7:0] plen, logic [7:0] pb, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    first_of_frame = first;
    cmd_primary    = pri;
    cmd_secondary  = sec;
    param_len      = plen;
    param_byte     = pb;
    last_of_frame  = last;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(first, pri, sec, plen, pb, last);
    @(negedge clk);
  endtask

  // non-first words carry random command and length fields, which must be ignored
  task automatic send_frame(logic [7:0] plen, int count, logic close);
    for (int i = 0; i < count; i++)
      send_word(i == 0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                (i == 0) ? plen : 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), close && (i == count - 1));
  endtask

  initial begin
    int r;
    int count;
    int n_random;
    logic [7:0] plen;
    rst            = 1'b1;
    in_valid       = 1'b0;
    first_of_frame = 1'b0;
    cmd_primary    = '0;
    cmd_secondary  = '0;
    param_len      = '0;
    param_byte     = '0;
    last_of_frame  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: stray words, one-word frames at the field extremes, wrap of
    // the length byte, abandon, overlong and short frames
    send_word(1'b0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    send_word(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    send_word(1'b1, 8'h00, 8'h00, 8'd1, 8'h00, 1'b1);
    send_word(1'b1, 8'hff, 8'hff, 8'd1, 8'hff, 1'b1);
    send_word(1'b1, 8'h5a, 8'ha5, 8'd0, 8'h3c, 1'b1);
    send_word(1'b1, 8'h12, 8'h34, 8'd255, 8'h56, 1'b1);
    send_word(1'b1, 8'h80, 8'h01, 8'd252, 8'h7f, 1'b1);
    send_word(1'b1, 8'h01, 8'h80, 8'h80, 8'h80, 1'b1);
    send_frame(8'd3, 3, 1'b1);
    send_frame(8'd2, 1, 1'b0);
    send_frame(8'd1, 1, 1'b1);
    send_frame(8'd1, 3, 1'b1);
    send_frame(8'd4, 2, 1'b1);

    // count runs past 255 and must saturate, so a declared 255 still matches
    quiet_sender = 1'b1;
    send_frame(8'd255, 258, 1'b1);
    quiet_sender = 1'b0;

    n_random = 0;
    while (n_random < 100) begin
      quiet_sender = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_word(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (r < 15) begin
        count = $urandom_range(1, 6);
        send_frame(8'($urandom_range(1, 8)), count, 1'b0);
        n_random += count;
      end else if (r < 25) begin
        count = $urandom_range(1, 10);
        send_frame(8'($urandom_range(0, 255)), count, 1'b1);
        n_random += count;
      end else if (r < 35) begin
        plen = 8'($urandom_range(2, 8));
        count = $urandom_range(0, 1) ? int'(plen) + 1 : int'(plen) - 1;
        send_frame(plen, count, 1'b1);
        n_random += count;
      end else begin
        plen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(11, 40))
                                           : 8'($urandom_range(1, 10));
        send_frame(plen, int'(plen), 1'b1);
        n_random += int'(plen);
      end
    end
    in_valid = 1'b0;

    r = 0;
    while (sb.pending_bytes.size() != 0 && r < 100000) begin
      @(negedge clk);
      r++;
    end
    repeat (10) @(negedge clk);
    sb.check_drained();

    $display("summary: %0d words sent, %0d bytes checked, %0d frames closed (%0d in error)",
             sb.n_words, sb.n_checked, sb.n_frames, sb.n_bad_frames);
    $display("summary: %0d stray words, %0d frames abandoned, %0d mismatches",
             sb.n_dropped, sb.n_abandoned, sb.n_mismatch);
    if (sb.n_mismatch == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cfb_pkg.sv
design/command_frame_builder_top.sv
tb/tb.sv
